// ----- sv/assert_macros.svh -----
// assertion macros used by the bus sequencer of the register access master rtl
// every macro expects clk and rst_n in scope at the place of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must hold in the cycle after a trigger
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- sv/ira_pkg.sv -----
// shared types and constants of the register access bus master
// used by every module of the block; depends on nothing
package ira_pkg;

  // default burst ceiling for read commands
  localparam int MAX_BURST_DEF = 16;

  // configuration port data width
  localparam int CFG_DATA_W = 16;

  // action codes of an input item (the unused code acts as a plain tick)
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR   = 2'd0;
  localparam logic [1:0] CFG_STEP_TICKS = 2'd1;
  localparam logic [1:0] CFG_POLL_TICKS = 2'd2;
  localparam logic [1:0] CFG_ACK_LIMIT  = 2'd3;

  // configuration reset values
  localparam logic [6:0]  DEV_ADDR_RST   = 7'd104;
  localparam logic [15:0] STEP_TICKS_RST = 16'd4;
  localparam logic [15:0] POLL_TICKS_RST = 16'd2;
  localparam logic [9:0]  ACK_LIMIT_RST  = 10'd100;

  // one timebase tick with optional command
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic [4:0] burst_length;
    logic       sda_sample;
  } item_t;

  // result of one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       last_byte;
    logic       done_res;
    logic       error;
  } res_t;

  // configuration register contents
  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] step_ticks;
    logic [15:0] poll_ticks;
    logic [9:0]  ack_poll_limit;
  } cfg_t;

endpackage

// ----- sv/ira_in_stage.sv -----
// input register of the register access master
// holds one accepted tick item until the sequencer takes it; uses ira_pkg
module ira_in_stage
  import ira_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_reg_address,
  input  logic [7:0] in_write_data,
  input  logic [4:0] in_burst_length,
  input  logic       in_sda_sample,
  input  logic       take,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // free when empty or emptied this cycle
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.action       <= in_action;
      item_r.reg_address  <= in_reg_address;
      item_r.write_data   <= in_write_data;
      item_r.burst_length <= in_burst_length;
      item_r.sda_sample   <= in_sda_sample;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- sv/ira_cfg_regs.sv -----
// configuration registers of the register access master
// plain write port, no read-back; uses ira_pkg
module ira_cfg_regs
  import ira_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= DEV_ADDR_RST;
      cfg_r.step_ticks     <= STEP_TICKS_RST;
      cfg_r.poll_ticks     <= POLL_TICKS_RST;
      cfg_r.ack_poll_limit <= ACK_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DEV_ADDR:   cfg_r.device_address <= cfg_data[6:0];
        CFG_STEP_TICKS: cfg_r.step_ticks     <= cfg_data[15:0];
        CFG_POLL_TICKS: cfg_r.poll_ticks     <= cfg_data[15:0];
        CFG_ACK_LIMIT:  cfg_r.ack_poll_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/ira_seq.sv -----
// bus sequencer of the register access master: state registers and one tick of step logic
// uses ira_pkg and the assertion macros
`include "assert_macros.svh"

module ira_seq
  import ira_pkg::*;
#(
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  localparam int CNT_W = $clog2(MAX_BURST + 1);
  localparam logic [8:0] MAX_BURST_9 = 9'(MAX_BURST);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_START_A   = 5'd1,
    ST_TX_WADDR  = 5'd2,
    ST_ACK_WADDR = 5'd3,
    ST_TX_REG    = 5'd4,
    ST_ACK_REG   = 5'd5,
    ST_TX_DATA   = 5'd6,
    ST_ACK_DATA  = 5'd7,
    ST_START_B   = 5'd8,
    ST_TX_RADDR  = 5'd9,
    ST_ACK_RADDR = 5'd10,
    ST_RX_BYTE   = 5'd11,
    ST_RX_ACK    = 5'd12,
    ST_STOP_OK   = 5'd13,
    ST_STOP_ERR  = 5'd14
  } step_t;

  // frame phases within a step
  localparam logic [2:0] PH_0    = 3'd0;
  localparam logic [2:0] PH_1    = 3'd1;
  localparam logic [2:0] PH_2    = 3'd2;
  localparam logic [2:0] PH_3    = 3'd3;
  localparam logic [2:0] PH_4    = 3'd4;
  localparam logic [2:0] PH_FAIL = 3'd4;

  step_t            step_r, step_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic [15:0]      hold_r, hold_nxt;
  logic [9:0]       retry_r, retry_nxt;
  logic [3:0]       bit_r, bit_nxt;
  logic [CNT_W-1:0] bytes_r, bytes_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             is_read_r, is_read_nxt;
  logic [7:0]       sreg_r, sreg_nxt;
  logic [7:0]       sdata_r, sdata_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;

  logic [15:0] hold_load;
  logic [15:0] poll_load;
  logic [7:0]  addr_w;
  logic [8:0]  len_9;
  logic [8:0]  len_clamp_9;
  logic        rx_last;
  logic        ack_fail;
  logic [9:0]  retry_inc;

  // acknowledge step that follows a transmit step
  function automatic step_t ack_of(step_t s);
    step_t r;
    case (s)
      ST_TX_WADDR: r = ST_ACK_WADDR;
      ST_TX_REG:   r = ST_ACK_REG;
      ST_TX_DATA:  r = ST_ACK_DATA;
      ST_TX_RADDR: r = ST_ACK_RADDR;
      default:     r = ST_IDLE;
    endcase
    return r;
  endfunction

  // hold reloads, zero acts as one
  assign hold_load = (cfg.step_ticks == '0) ? '0 : cfg.step_ticks - 16'd1;
  assign poll_load = (cfg.poll_ticks == '0) ? '0 : cfg.poll_ticks - 16'd1;
  assign addr_w    = {cfg.device_address, 1'b0};

  // burst length clamp
  assign len_9       = {4'd0, item.burst_length};
  assign len_clamp_9 = (len_9 > MAX_BURST_9) ? MAX_BURST_9 : len_9;

  // one tick: command capture, then either a hold countdown or one bus action
  always_comb begin
    step_nxt    = step_r;
    phase_nxt   = phase_r;
    hold_nxt    = hold_r;
    retry_nxt   = retry_r;
    bit_nxt     = bit_r;
    bytes_nxt   = bytes_r;
    shift_nxt   = shift_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    is_read_nxt = is_read_r;
    sreg_nxt    = sreg_r;
    sdata_nxt   = sdata_r;
    len_nxt     = len_r;
    res         = '0;
    rx_last     = 1'b0;
    ack_fail    = 1'b0;
    retry_inc   = retry_r + 10'd1;

    // command capture while idle
    if (step_r == ST_IDLE && (item.action == ACT_WRITE || item.action == ACT_READ)) begin
      if (item.action == ACT_READ && item.burst_length == 5'd0) begin
        res.done_res = 1'b1;
        res.error    = 1'b1;
      end else begin
        is_read_nxt = (item.action == ACT_READ);
        sreg_nxt    = item.reg_address;
        sdata_nxt   = item.write_data;
        len_nxt     = CNT_W'(len_clamp_9);
        bytes_nxt   = '0;
        retry_nxt   = '0;
        step_nxt    = ST_START_A;
        phase_nxt   = PH_0;
        hold_nxt    = '0;
      end
    end

    if (step_nxt != ST_IDLE) begin
      if (hold_nxt != '0) begin
        hold_nxt = hold_nxt - 16'd1;
      end else begin
        case (step_nxt)
          // start and repeated start
          ST_START_A, ST_START_B: begin
            hold_nxt = hold_load;
            case (phase_nxt)
              PH_0: begin
                sda_nxt   = 1'b1;
                phase_nxt = PH_1;
              end
              PH_1: begin
                scl_nxt   = 1'b1;
                phase_nxt = PH_2;
              end
              PH_2: begin
                sda_nxt   = 1'b0;
                phase_nxt = PH_3;
              end
              default: begin
                scl_nxt   = 1'b0;
                phase_nxt = PH_0;
                bit_nxt   = '0;
                if (step_nxt == ST_START_A) begin
                  step_nxt  = ST_TX_WADDR;
                  shift_nxt = addr_w;
                end else begin
                  step_nxt  = ST_TX_RADDR;
                  shift_nxt = addr_w | 8'h01;
                end
              end
            endcase
          end

          // byte transmit, msb first
          ST_TX_WADDR, ST_TX_REG, ST_TX_DATA, ST_TX_RADDR: begin
            hold_nxt = hold_load;
            case (phase_nxt)
              PH_0: begin
                scl_nxt   = 1'b0;
                phase_nxt = PH_1;
              end
              PH_1: begin
                sda_nxt   = shift_nxt[7];
                shift_nxt = {shift_nxt[6:0], 1'b0};
                phase_nxt = PH_2;
              end
              PH_2: begin
                scl_nxt   = 1'b1;
                bit_nxt   = bit_nxt + 4'd1;
                phase_nxt = (bit_nxt >= 4'd8) ? PH_3 : PH_0;
              end
              default: begin
                scl_nxt   = 1'b0;
                step_nxt  = ack_of(step_nxt);
                phase_nxt = PH_0;
                retry_nxt = '0;
              end
            endcase
          end

          // acknowledge poll from the target
          ST_ACK_WADDR, ST_ACK_REG, ST_ACK_DATA, ST_ACK_RADDR: begin
            case (phase_nxt)
              PH_0: begin
                sda_nxt   = 1'b1;
                hold_nxt  = hold_load;
                phase_nxt = PH_1;
              end
              PH_1: begin
                scl_nxt   = 1'b1;
                hold_nxt  = hold_load;
                phase_nxt = PH_2;
              end
              PH_2: begin
                if (!item.sda_sample) begin
                  hold_nxt  = '0;
                  phase_nxt = PH_3;
                end else begin
                  retry_nxt = retry_inc;
                  hold_nxt  = poll_load;
                  if (retry_inc >= cfg.ack_poll_limit) begin
                    phase_nxt = PH_FAIL;
                  end
                end
              end
              default: begin
                scl_nxt  = 1'b0;
                hold_nxt = hold_load;
                ack_fail = (phase_nxt == PH_FAIL);
                phase_nxt = PH_0;
                if (ack_fail) begin
                  step_nxt = ST_STOP_ERR;
                end else begin
                  case (step_nxt)
                    ST_ACK_WADDR: begin
                      step_nxt  = ST_TX_REG;
                      bit_nxt   = '0;
                      shift_nxt = sreg_r;
                    end
                    ST_ACK_REG: begin
                      if (is_read_nxt) begin
                        step_nxt = ST_START_B;
                      end else begin
                        step_nxt  = ST_TX_DATA;
                        bit_nxt   = '0;
                        shift_nxt = sdata_r;
                      end
                    end
                    ST_ACK_RADDR: begin
                      bytes_nxt = '0;
                      step_nxt  = ST_RX_BYTE;
                      bit_nxt   = '0;
                      shift_nxt = '0;
                    end
                    default: step_nxt = ST_STOP_OK;
                  endcase
                end
              end
            endcase
          end

          // byte receive, sampled as the clock is pulled low
          ST_RX_BYTE: begin
            hold_nxt = hold_load;
            if (phase_nxt == PH_0) begin
              if (bit_nxt != '0) begin
                shift_nxt = {shift_nxt[6:0], item.sda_sample};
              end
              scl_nxt = 1'b0;
              if (bit_nxt >= 4'd8) begin
                bytes_nxt      = bytes_nxt + CNT_W'(1);
                res.read_byte  = shift_nxt;
                res.byte_valid = 1'b1;
                res.last_byte  = (bytes_nxt >= len_nxt);
                step_nxt       = ST_RX_ACK;
                phase_nxt      = PH_0;
              end else begin
                sda_nxt   = 1'b1;
                phase_nxt = PH_1;
              end
            end else begin
              scl_nxt   = 1'b1;
              bit_nxt   = bit_nxt + 4'd1;
              phase_nxt = PH_0;
            end
          end

          // master acknowledge, released on the last byte
          ST_RX_ACK: begin
            rx_last  = (bytes_nxt >= len_nxt);
            hold_nxt = hold_load;
            case (phase_nxt)
              PH_0: begin
                scl_nxt   = 1'b0;
                phase_nxt = PH_1;
              end
              PH_1: begin
                sda_nxt   = rx_last;
                phase_nxt = PH_2;
              end
              PH_2: begin
                scl_nxt   = 1'b1;
                phase_nxt = PH_3;
              end
              default: begin
                scl_nxt   = 1'b0;
                phase_nxt = PH_0;
                if (rx_last) begin
                  step_nxt = ST_STOP_OK;
                end else begin
                  step_nxt  = ST_RX_BYTE;
                  bit_nxt   = '0;
                  shift_nxt = '0;
                end
              end
            endcase
          end

          // stop condition, then report
          ST_STOP_OK, ST_STOP_ERR: begin
            case (phase_nxt)
              PH_0: begin
                scl_nxt   = 1'b0;
                hold_nxt  = hold_load;
                phase_nxt = PH_1;
              end
              PH_1: begin
                sda_nxt   = 1'b0;
                hold_nxt  = hold_load;
                phase_nxt = PH_2;
              end
              PH_2: begin
                scl_nxt   = 1'b1;
                hold_nxt  = hold_load;
                phase_nxt = PH_3;
              end
              PH_3: begin
                sda_nxt   = 1'b1;
                hold_nxt  = hold_load;
                phase_nxt = PH_4;
              end
              default: begin
                res.done_res = 1'b1;
                res.error    = (step_nxt == ST_STOP_ERR);
                step_nxt     = ST_IDLE;
                phase_nxt    = PH_0;
                hold_nxt     = '0;
              end
            endcase
          end

          default: begin
            step_nxt  = ST_IDLE;
            phase_nxt = PH_0;
            hold_nxt  = '0;
          end
        endcase
      end
    end

    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.busy_res  = (step_nxt != ST_IDLE);
  end

  // state registers, advanced once per tick item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= ST_IDLE;
      phase_r   <= PH_0;
      hold_r    <= '0;
      retry_r   <= '0;
      bit_r     <= '0;
      bytes_r   <= '0;
      shift_r   <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      is_read_r <= 1'b0;
      sreg_r    <= '0;
      sdata_r   <= '0;
      len_r     <= '0;
    end else if (step_en) begin
      step_r    <= step_nxt;
      phase_r   <= phase_nxt;
      hold_r    <= hold_nxt;
      retry_r   <= retry_nxt;
      bit_r     <= bit_nxt;
      bytes_r   <= bytes_nxt;
      shift_r   <= shift_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      is_read_r <= is_read_nxt;
      sreg_r    <= sreg_nxt;
      sdata_r   <= sdata_nxt;
      len_r     <= len_nxt;
    end
  end

  // a pending hold only exists inside a transaction
  `ASSERT_CLK(a_hold_busy, (hold_r != '0) |-> (step_r != ST_IDLE), "hold count while idle")

  // received byte count never passes the burst length
  `ASSERT_CLK(a_bytes_le_len, bytes_r <= len_r, "byte count beyond burst length")

  // bytes are only reported from the receive step
  `ASSERT_CLK(a_byte_src, res.byte_valid |-> (step_r == ST_RX_BYTE), "byte outside receive")

  // a finished transaction leaves the sequencer idle
  `ASSERT_NEXT(a_done_idle, step_en && res.done_res, step_r == ST_IDLE, "not idle after done")

endmodule

// ----- sv/ira_out_stage.sv -----
// result register of the register access master
// parts the sequencer from a stalled consumer; uses ira_pkg
module ira_out_stage
  import ira_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  res_t       res,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_busy_res,
  output logic [7:0] out_read_byte,
  output logic       out_byte_valid,
  output logic       out_last_byte,
  output logic       out_done_res,
  output logic       out_error
);

  logic valid_r, valid_nxt;
  res_t res_r;

  // room for a new result when empty or draining
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_valid      = valid_r;
  assign out_scl_level  = res_r.scl_level;
  assign out_sda_level  = res_r.sda_level;
  assign out_busy_res   = res_r.busy_res;
  assign out_read_byte  = res_r.read_byte;
  assign out_byte_valid = res_r.byte_valid;
  assign out_last_byte  = res_r.last_byte;
  assign out_done_res   = res_r.done_res;
  assign out_error      = res_r.error;

endmodule

// ----- sv/i2c_register_access_master.sv -----
// Register access bus master, top level. Each input item is one timebase tick and gives
// exactly one result item with the bus pin drives and status for that tick. An item is
// registered on entry, stepped through the bus sequencer once the result register has
// room and its result held in a result register until the consumer takes it; one item
// is taken in every clock cycle while the consumer keeps up, and the single sequencer
// state update per tick sets that figure. Bus timing is counted in ticks: every pin change
// holds step_ticks ticks, an acknowledge is polled every poll_ticks ticks up to
// ack_poll_limit times. Configuration is written through cfg_wr_en, cfg_index and
// cfg_data; the user must write it only while idle, the block does not enforce this.
// Depends on ira_pkg, ira_in_stage, ira_cfg_regs, ira_seq and ira_out_stage.
module i2c_register_access_master
  import ira_pkg::*;
#(
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [7:0]            in_reg_address,
  input  logic [7:0]            in_write_data,
  input  logic [4:0]            in_burst_length,
  input  logic                  in_sda_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_scl_level,
  output logic                  out_sda_level,
  output logic                  out_busy_res,
  output logic [7:0]            out_read_byte,
  output logic                  out_byte_valid,
  output logic                  out_last_byte,
  output logic                  out_done_res,
  output logic                  out_error,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  item_valid;
  item_t item;
  cfg_t  cfg;
  res_t  res;
  logic  out_free;
  logic  advance;

  // one tick is processed when an item waits and the result register has room
  assign advance = item_valid && out_free;

  ira_in_stage u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_reg_address  (in_reg_address),
    .in_write_data   (in_write_data),
    .in_burst_length (in_burst_length),
    .in_sda_sample   (in_sda_sample),
    .take            (advance),
    .item_valid      (item_valid),
    .item            (item)
  );

  ira_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ira_seq #(
    .MAX_BURST (MAX_BURST)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item),
    .cfg     (cfg),
    .res     (res)
  );

  ira_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (advance),
    .res            (res),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_scl_level  (out_scl_level),
    .out_sda_level  (out_sda_level),
    .out_busy_res   (out_busy_res),
    .out_read_byte  (out_read_byte),
    .out_byte_valid (out_byte_valid),
    .out_last_byte  (out_last_byte),
    .out_done_res   (out_done_res),
    .out_error      (out_error)
  );

endmodule
